// File: design/lsbc_pkg.sv
// Shared types and constants for the LED slot blink controller.
package lsbc_pkg;

  // Default slot count
  localparam int NUM_SLOTS_DEF = 5;

  // Microseconds per millisecond
  localparam int US_PER_MS = 1000;

  // Reset phase length in milliseconds
  localparam logic [15:0] BLINK_MS_RST = 16'd100;

  // Input opcodes
  localparam logic [2:0] OP_SET_COLOR = 3'd0;
  localparam logic [2:0] OP_BLINK     = 3'd1;
  localparam logic [2:0] OP_BLINK2    = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_ANIM      = 3'd4;

  // Result actions
  localparam logic [1:0] ACT_DRAW = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Per-slot blink modes
  localparam logic [1:0] MODE_SOLID = 2'd0;
  localparam logic [1:0] MODE_ONCE  = 2'd1;
  localparam logic [1:0] MODE_TWICE = 2'd2;

  // Input beat
  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  slot;
    logic [31:0] color;
    logic [15:0] elapsed_us;
  } lsbc_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  pixel_slot;
    logic [31:0] pixel_color;
    logic        last;
  } lsbc_out_t;

endpackage

// File: design/led_slot_blink_controller.sv
// LED slot blink controller: an input beat updates all slot state when it is taken and
// loads a result buffer of fixed positions (stop, one draw per slot, push) with a
// valid mask; the buffer drains one result beat per cycle in that order while out_ready
// is high. An item that causes no result or one result lets a new item in every cycle
// while the output is not stalled. An item has at most NUM_SLOTS + 1 result beats, six
// at the default, and the next item is taken in the cycle the last of its result beats
// leaves; the single result port draining that buffer sets the rate.
module led_slot_blink_controller
  import lsbc_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lsbc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lsbc_out_t   out_data,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  // Buffer positions: stop, one draw per slot, push
  localparam int ENT = NUM_SLOTS + 2;

  // Configuration: phase length kept in microseconds
  logic [31:0] phase_len_us;

  // Slot state
  logic                anim_mode, anim_mode_next;
  logic [1:0]          slot_mode      [NUM_SLOTS];
  logic [1:0]          slot_mode_next [NUM_SLOTS];
  logic                phase_on       [NUM_SLOTS];
  logic                phase_on_next  [NUM_SLOTS];
  logic [31:0]         timer_us       [NUM_SLOTS];
  logic [31:0]         timer_us_next  [NUM_SLOTS];
  logic [31:0]         resting        [NUM_SLOTS];
  logic [31:0]         resting_next   [NUM_SLOTS];
  logic [31:0]         flash          [NUM_SLOTS];
  logic [31:0]         flash_next     [NUM_SLOTS];

  // Result buffer
  logic [ENT-1:0]      res_mask, res_mask_next;
  logic [31:0]         draw_color      [NUM_SLOTS];
  logic [31:0]         draw_color_next [NUM_SLOTS];

  logic [ENT-1:0]      sel_oh;
  logic                in_fire, out_fire;

  // Handshake
  assign sel_oh    = res_mask & (~res_mask + ENT'(1));
  assign out_valid = |res_mask;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = !out_valid || (out_ready && $onehot(res_mask));
  assign in_fire   = in_valid && in_ready;

  // Present the lowest pending result beat
  always_comb begin
    out_data.action      = ACT_DRAW;
    out_data.pixel_slot  = '0;
    out_data.pixel_color = '0;
    out_data.last        = $onehot(res_mask);
    if (sel_oh[0]) begin
      out_data.action = ACT_STOP;
    end
    if (sel_oh[ENT-1]) begin
      out_data.action = ACT_PUSH;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel_oh[i+1]) begin
        out_data.pixel_slot  = 3'(i);
        out_data.pixel_color = draw_color[i];
      end
    end
  end

  // Next slot state and result buffer
  always_comb begin
    logic        slot_ok;
    logic        is_cmd;
    logic        stepped;
    logic [32:0] sum;
    logic [31:0] t;

    slot_ok = (in_data.opcode > OP_BLINK2) || (int'(in_data.slot) < NUM_SLOTS);
    is_cmd  = (in_data.opcode == OP_BLINK) || (in_data.opcode == OP_BLINK2);
    stepped = 1'b0;
    sum     = '0;
    t       = '0;

    anim_mode_next = anim_mode;
    res_mask_next  = out_fire ? (res_mask & ~sel_oh) : res_mask;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mode_next[i]  = slot_mode[i];
      phase_on_next[i]   = phase_on[i];
      timer_us_next[i]   = timer_us[i];
      resting_next[i]    = resting[i];
      flash_next[i]      = flash[i];
      draw_color_next[i] = draw_color[i];
    end

    if (in_fire) begin
      res_mask_next = '0;
      if (slot_ok) begin
        case (in_data.opcode)
          OP_SET_COLOR, OP_BLINK, OP_BLINK2: begin
            // Leave animation mode with a stop, then draw and push; blink commands always draw and push
            if (anim_mode) begin
              res_mask_next[0] = 1'b1;
              anim_mode_next   = 1'b0;
            end
            if (anim_mode || is_cmd) begin
              res_mask_next[ENT-1] = 1'b1;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (int'(in_data.slot) == i) begin
                if (anim_mode || is_cmd) begin
                  res_mask_next[i+1] = 1'b1;
                  draw_color_next[i] = in_data.color;
                end
                if (is_cmd) begin
                  slot_mode_next[i] = (in_data.opcode == OP_BLINK) ? MODE_ONCE : MODE_TWICE;
                  timer_us_next[i]  = '0;
                  phase_on_next[i]  = 1'b1;
                  flash_next[i]     = in_data.color;
                end else begin
                  resting_next[i] = in_data.color;
                end
              end
            end
          end
          OP_TICK: begin
            // Outside animation mode, advance every blinking slot and step those whose phase ran out
            if (!anim_mode) begin
              for (int i = 0; i < NUM_SLOTS; i++) begin
                sum = {1'b0, timer_us[i]} + 33'(in_data.elapsed_us);
                t   = sum[32] ? '1 : sum[31:0];
                if (slot_mode[i] == MODE_ONCE || slot_mode[i] == MODE_TWICE) begin
                  timer_us_next[i] = t;
                  if (t >= phase_len_us) begin
                    stepped            = 1'b1;
                    res_mask_next[i+1] = 1'b1;
                    if (phase_on[i]) begin
                      draw_color_next[i] = '0;
                      phase_on_next[i]   = 1'b0;
                      timer_us_next[i]   = '0;
                    end else if (slot_mode[i] == MODE_ONCE) begin
                      draw_color_next[i] = resting[i];
                      slot_mode_next[i]  = MODE_SOLID;
                    end else begin
                      draw_color_next[i] = flash[i];
                      slot_mode_next[i]  = MODE_ONCE;
                      phase_on_next[i]   = 1'b1;
                      timer_us_next[i]   = '0;
                    end
                  end
                end
              end
              res_mask_next[ENT-1] = stepped;
            end
          end
          OP_ANIM: begin
            anim_mode_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_len_us <= 32'(BLINK_MS_RST) * 32'(US_PER_MS);
      anim_mode    <= 1'b0;
      res_mask     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_mode[i] <= MODE_SOLID;
        phase_on[i]  <= 1'b0;
        timer_us[i]  <= '0;
        resting[i]   <= '0;
        flash[i]     <= '0;
      end
    end else begin
      if (cfg_wen) begin
        phase_len_us <= 32'(cfg_wdata) * 32'(US_PER_MS);
      end
      anim_mode <= anim_mode_next;
      res_mask  <= res_mask_next;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_mode[i] <= slot_mode_next[i];
        phase_on[i]  <= phase_on_next[i];
        timer_us[i]  <= timer_us_next[i];
        resting[i]   <= resting_next[i];
        flash[i]     <= flash_next[i];
      end
    end
  end

  // Draw colors held in the result buffer
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      draw_color[i] <= draw_color_next[i];
    end
  end

  // A new beat is taken only while no result is pending or a result leaves in the same cycle
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken while results stalled");

  // A stop beat is never the last beat of its group
  a_stop_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == ACT_STOP |-> !out_data.last)
    else $error("stop beat marked last");

  // Push closes every result group
  a_push_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action == ACT_PUSH |-> out_data.last)
    else $error("push beat not last");

  // Entering animation mode takes effect on the next cycle
  a_anim_set: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == OP_ANIM |=> anim_mode)
    else $error("animation mode not entered");

endmodule

// File: tb/sv/led_slot_blink_controller_tb.sv
// Self-checking testbench for the LED slot blink controller: command driver, result monitor.
module led_slot_blink_controller_tb;
  import lsbc_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int QUIET_LIMIT = 300;
  localparam int RAND_PER_PHASE = 47;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    lsbc_in_t    beat;
    int unsigned gap;
  } cmd_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lsbc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lsbc_out_t   out_data;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Commands waiting to be driven, and result beats the display logic still owes
  cmd_slot_t cmd_backlog[$];
  lsbc_out_t pending_actions[$];

  // Shadow of the controller state
  logic [15:0] p_blink_ms = BLINK_MS_RST;
  logic        p_anim = 1'b0;
  logic [1:0]  p_mode  [SLOTS];
  logic        p_lit   [SLOTS];
  logic [31:0] p_timer [SLOTS];
  logic [31:0] p_rest  [SLOTS];
  logic [31:0] p_flash [SLOTS];

  bit in_lazy = 1'b1;
  bit out_lazy = 1'b1;
  int stall_left = 0;
  int cmds_queued = 0;
  int cmds_taken = 0;
  int actions_seen = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int settings_used = 1;

  led_slot_blink_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic lsbc_out_t action_beat(input logic [1:0] act, input logic [2:0] slot,
                                            input logic [31:0] color);
    lsbc_out_t r;
    r.action = act;
    r.pixel_slot = slot;
    r.pixel_color = color;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the shadow state by one command and queue the display actions it causes
  function automatic void predict_actions(input lsbc_in_t b);
    lsbc_out_t   acts[$];
    logic [31:0] thr;
    logic [32:0] sum;
    bit          stepped;
    int          i;
    stepped = 1'b0;
    thr = 32'(p_blink_ms) * 32'(US_PER_MS);
    // drop slot commands aimed past the last slot
    if (b.opcode <= OP_BLINK2 && b.slot >= SLOTS) return;
    case (b.opcode)
      OP_SET_COLOR: begin
        p_rest[b.slot] = b.color;
        if (p_anim) begin
          acts.push_back(action_beat(ACT_STOP, 3'd0, 32'd0));
          p_anim = 1'b0;
          acts.push_back(action_beat(ACT_DRAW, b.slot, b.color));
          acts.push_back(action_beat(ACT_PUSH, 3'd0, 32'd0));
        end
      end
      OP_BLINK, OP_BLINK2: begin
        if (p_anim) begin
          acts.push_back(action_beat(ACT_STOP, 3'd0, 32'd0));
          p_anim = 1'b0;
        end
        acts.push_back(action_beat(ACT_DRAW, b.slot, b.color));
        acts.push_back(action_beat(ACT_PUSH, 3'd0, 32'd0));
        p_mode[b.slot] = (b.opcode == OP_BLINK) ? MODE_ONCE : MODE_TWICE;
        p_timer[b.slot] = '0;
        p_lit[b.slot] = 1'b1;
        p_flash[b.slot] = b.color;
      end
      OP_TICK: begin
        if (!p_anim) begin
          for (i = 0; i < SLOTS; i++) begin
            if (p_mode[i] == MODE_ONCE || p_mode[i] == MODE_TWICE) begin
              // saturate the phase timer
              sum = {1'b0, p_timer[i]} + 33'(b.elapsed_us);
              p_timer[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (p_timer[i] >= thr) begin
                stepped = 1'b1;
                if (p_lit[i]) begin
                  acts.push_back(action_beat(ACT_DRAW, 3'(i), 32'd0));
                  p_lit[i] = 1'b0;
                  p_timer[i] = '0;
                end else if (p_mode[i] == MODE_ONCE) begin
                  p_mode[i] = MODE_SOLID;
                  acts.push_back(action_beat(ACT_DRAW, 3'(i), p_rest[i]));
                end else begin
                  acts.push_back(action_beat(ACT_DRAW, 3'(i), p_flash[i]));
                  p_mode[i] = MODE_ONCE;
                  p_lit[i] = 1'b1;
                  p_timer[i] = '0;
                end
              end
            end
          end
          if (stepped) acts.push_back(action_beat(ACT_PUSH, 3'd0, 32'd0));
        end
      end
      OP_ANIM: p_anim = 1'b1;
      default: ;
    endcase
    if (acts.size() > 0) acts[acts.size() - 1].last = 1'b1;
    foreach (acts[k]) pending_actions.push_back(acts[k]);
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [2:0] slot,
                           input logic [31:0] color, input logic [15:0] us);
    cmd_slot_t c;
    c.beat.opcode = op;
    c.beat.slot = slot;
    c.beat.color = color;
    c.beat.elapsed_us = us;
    c.gap = in_lazy ? $urandom_range(0, 12) : 0;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  // Hold until every command is taken and every owed beat has come out
  task automatic wait_idle();
    do @(posedge clk);
    while (cmds_taken != cmds_queued || pending_actions.size() != 0);
    // let result-free commands finish inside the block
    repeat (4) @(posedge clk);
  endtask

  task automatic write_blink_ms(input logic [15:0] ms);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_wen <= 1'b0;
    p_blink_ms = ms;
    settings_used++;
  endtask

  // Drive command beats from the backlog, honoring each one's lead-in gap
  always @(posedge clk) begin : drive_cmds
    cmd_slot_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_actions(in_data);
        cmds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_backlog[0].gap != 0) begin
          cmd_backlog[0].gap--;
          in_valid <= 1'b0;
        end else begin
          nxt = cmd_backlog.pop_front();
          in_data <= nxt.beat;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Check each result beat against the oldest owed action, then maybe stall
  always @(posedge clk) begin : watch_actions
    lsbc_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        actions_seen++;
        if (pending_actions.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected beat: act=%0d slot=%0d color=%h last=%0b",
                     out_data.action, out_data.pixel_slot, out_data.pixel_color,
                     out_data.last);
        end else begin
          want = pending_actions.pop_front();
          if (out_data.action !== want.action || out_data.pixel_slot !== want.pixel_slot ||
              out_data.pixel_color !== want.pixel_color || out_data.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("beat %0d: expected act=%0d slot=%0d color=%h last=%0b, got act=%0d slot=%0d color=%h last=%0b",
                       actions_seen, want.action, want.pixel_slot, want.pixel_color,
                       want.last, out_data.action, out_data.pixel_slot,
                       out_data.pixel_color, out_data.last);
          end
        end
        stall_left = out_lazy ? $urandom_range(0, 12) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Count cycles with no handshake on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] phase_ms [8];
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [31:0] color;
    logic [15:0] us;
    int          pick;
    for (int i = 0; i < SLOTS; i++) begin
      p_mode[i] = MODE_SOLID;
      p_lit[i] = 1'b0;
      p_timer[i] = '0;
      p_rest[i] = '0;
      p_flash[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset phase length: colors, out-of-range slots, both blink kinds, animation exits
    queue_cmd(OP_SET_COLOR, 3'd0, 32'hFFFF_FFFF, 16'd0);
    queue_cmd(OP_SET_COLOR, 3'd4, 32'h1234_5678, 16'hFFFF);
    queue_cmd(OP_SET_COLOR, 3'd5, 32'hDEAD_BEEF, 16'd0);
    queue_cmd(OP_BLINK, 3'd7, 32'hFFFF_FFFF, 16'd0);
    queue_cmd(OP_BLINK, 3'd0, 32'hA5A5_A5A5, 16'd0);
    queue_cmd(OP_BLINK2, 3'd4, 32'h5A5A_5A5A, 16'd0);
    repeat (4) queue_cmd(OP_TICK, 3'd0, 32'd0, 16'hFFFF);
    queue_cmd(OP_ANIM, 3'd0, 32'd0, 16'd0);
    queue_cmd(OP_TICK, 3'd0, 32'd0, 16'hFFFF);
    queue_cmd(OP_SET_COLOR, 3'd2, 32'h0000_0000, 16'd0);
    queue_cmd(OP_ANIM, 3'd0, 32'd0, 16'd0);
    queue_cmd(OP_BLINK, 3'd1, 32'hFFFF_0000, 16'd0);
    queue_cmd(OP_ANIM, 3'd0, 32'd0, 16'd0);
    queue_cmd(OP_BLINK2, 3'd6, 32'h0F0F_0F0F, 16'd0);
    queue_cmd(OP_BLINK2, 3'd3, 32'h0000_FFFF, 16'd0);
    queue_cmd(3'd5, 3'd0, 32'd0, 16'd0);
    queue_cmd(3'd7, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    wait_idle();

    // Zero phase length: every tick steps every blinking slot, then a push
    write_blink_ms(16'd0);
    queue_cmd(OP_BLINK, 3'd0, 32'h8001_8001, 16'd0);
    queue_cmd(OP_BLINK2, 3'd2, 32'h7FFE_7FFE, 16'd0);
    repeat (3) queue_cmd(OP_TICK, 3'd0, 32'd0, 16'd0);
    wait_idle();

    // Random phases over a spread of phase lengths, extremes included
    phase_ms = '{16'd1, 16'hFFFF, BLINK_MS_RST, 16'd0, 16'($urandom_range(0, 4)),
                 16'($urandom), 16'd1, 16'd2};
    foreach (phase_ms[p]) begin
      write_blink_ms(phase_ms[p]);
      in_lazy = $urandom_range(0, 2) != 0;
      out_lazy = $urandom_range(0, 2) != 0;
      repeat (RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_TICK;
        else if (pick < 55) op = OP_BLINK;
        else if (pick < 68) op = OP_BLINK2;
        else if (pick < 84) op = OP_SET_COLOR;
        else if (pick < 93) op = OP_ANIM;
        else op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0) slot = 3'($urandom_range(SLOTS, 7));
        else slot = 3'($urandom_range(0, SLOTS - 1));
        color = $urandom;
        case ($urandom_range(0, 3))
          0: us = 16'hFFFF;
          1: us = 16'($urandom_range(0, 2000));
          default: us = 16'($urandom);
        endcase
        queue_cmd(op, slot, color, us);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (pending_actions.size() != 0)
      $display("%0d result beats never arrived", pending_actions.size());
    $display("%0d commands over %0d phase lengths, %0d result beats checked, %0d bad",
             cmds_taken, settings_used, actions_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_actions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
